// File: rtl/psrq_pkg.sv
`timescale 1ns / 1ps

package psrq_pkg;

  localparam int NumSlotsDef  = 4;
  localparam int SlotBytesDef = 64;

  localparam int CmdW    = 2;
  localparam int ByteW   = 8;
  localparam int StatusW = 3;
  localparam int LenW    = 7;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH = 2'd0,
    CMD_END  = 2'd1,
    CMD_POP  = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_TAKEN  = 3'd0,
    ST_ACCEPT = 3'd1,
    ST_REJECT = 3'd2,
    ST_BYTE   = 3'd3,
    ST_EMPTY  = 3'd4
  } status_e;

endpackage

// File: rtl/psrq_byte_ram.sv
`timescale 1ns / 1ps

module psrq_byte_ram #(
  parameter int Depth = psrq_pkg::NumSlotsDef * psrq_pkg::SlotBytesDef,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [psrq_pkg::ByteW-1:0] wdata_i,
  input  logic [AddrW-1:0]           raddr_i,
  output logic [psrq_pkg::ByteW-1:0] rdata_o
);

  logic [psrq_pkg::ByteW-1:0] mem_q [Depth];
  logic [psrq_pkg::ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/packet_slot_ring_queue_unit.sv
// Ring queue of whole packets in fixed slots. Issue a command with start while busy is low:
// push a byte, end (commit or reject the gathered packet) or pop the oldest packet. Every
// command except an unused code gives its results starting in the cycle after the transfer, each
// marked by strobe for exactly one cycle; the receiver cannot stall them. Push, end, a pop of
// an empty queue and a pop of a zero-length packet give one result and leave busy low, so they
// may follow each other in every cycle. A pop of a packet of L bytes streams one byte a cycle
// from the single read port of the slot byte memory, holding busy high until the final byte, so
// the next command may be issued in the cycle that shows the final byte.
`timescale 1ns / 1ps

module packet_slot_ring_queue_unit #(
  parameter int NumSlots  = psrq_pkg::NumSlotsDef,
  parameter int SlotBytes = psrq_pkg::SlotBytesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [psrq_pkg::CmdW-1:0]    command_i,
  input  logic [psrq_pkg::ByteW-1:0]   in_byte_i,
  output logic                         strobe,
  output logic [psrq_pkg::StatusW-1:0] status_o,
  output logic [psrq_pkg::ByteW-1:0]   out_byte_o,
  output logic                         byte_valid_o,
  output logic [psrq_pkg::LenW-1:0]    packet_length_o,
  output logic                         last_o,
  output logic [$clog2(NumSlots+1)-1:0] queue_count_o
);

  localparam int LenW   = psrq_pkg::LenW;
  localparam int SlotW  = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int IdxW   = (SlotBytes > 1) ? $clog2(SlotBytes) : 1;
  localparam int CountW = $clog2(NumSlots + 1);
  localparam int SumW   = CountW + 1;
  localparam int Depth  = NumSlots * SlotBytes;
  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;

  // queue state
  logic [SlotW-1:0]  head_q, head_d;
  logic [CountW-1:0] count_q, count_d;
  logic [LenW-1:0]   gather_q, gather_d;
  logic              reject_q, reject_d;
  logic [LenW-1:0]   len_q [NumSlots];

  // single-result response
  logic              resp_valid_q, resp_valid_d;
  psrq_pkg::status_e resp_status_q, resp_status_d;
  logic [LenW-1:0]   resp_len_q, resp_len_d;

  // byte streaming
  logic              stream_q, stream_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [LenW-1:0]   slen_q, slen_d;
  logic [SlotW-1:0]  sslot_q, sslot_d;

  logic              accept;
  logic              last_beat;
  logic              full;
  logic              gather_full;
  logic [SumW-1:0]   tail_sum;
  logic [SlotW-1:0]  tail;
  logic [SlotW-1:0]  head_next;
  logic [LenW-1:0]   head_len;
  logic              len_we;
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [AddrW-1:0]  ram_raddr;
  logic [psrq_pkg::ByteW-1:0] ram_rdata;

  assign full        = (count_q == CountW'(NumSlots));
  assign gather_full = (gather_q >= LenW'(SlotBytes));
  assign tail_sum    = SumW'(head_q) + SumW'(count_q);
  assign tail        = (tail_sum >= SumW'(NumSlots)) ? SlotW'(tail_sum - SumW'(NumSlots))
                                                     : SlotW'(tail_sum);
  assign head_next   = (head_q == SlotW'(NumSlots - 1)) ? '0 : head_q + SlotW'(1);
  assign head_len    = len_q[head_q];

  assign last_beat = stream_q && (LenW'(idx_q) == slen_q - LenW'(1));
  assign busy      = stream_q && !last_beat;
  assign accept    = start && !busy;

  assign ram_we    = accept && (psrq_pkg::cmd_e'(command_i) == psrq_pkg::CMD_PUSH)
                     && !full && !gather_full && !reject_q;
  assign ram_waddr = AddrW'(tail) * AddrW'(SlotBytes) + AddrW'(gather_q[IdxW-1:0]);
  assign ram_raddr = accept ? AddrW'(head_q) * AddrW'(SlotBytes)
                            : AddrW'(sslot_q) * AddrW'(SlotBytes) + AddrW'(idx_q) + AddrW'(1);

  psrq_byte_ram #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_byte_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    head_d        = head_q;
    count_d       = count_q;
    gather_d      = gather_q;
    reject_d      = reject_q;
    resp_valid_d  = 1'b0;
    resp_status_d = resp_status_q;
    resp_len_d    = resp_len_q;
    stream_d      = stream_q && !last_beat;
    idx_d         = idx_q + IdxW'(1);
    slen_d        = slen_q;
    sslot_d       = sslot_q;
    len_we        = 1'b0;
    if (accept) begin
      case (psrq_pkg::cmd_e'(command_i))
        psrq_pkg::CMD_PUSH: begin
          if (full || gather_full) begin
            reject_d = 1'b1;
          end
          if (!gather_full) begin
            gather_d = gather_q + LenW'(1);
          end
          resp_valid_d  = 1'b1;
          resp_status_d = psrq_pkg::ST_TAKEN;
          resp_len_d    = gather_d;
        end
        psrq_pkg::CMD_END: begin
          if (full || reject_q) begin
            resp_status_d = psrq_pkg::ST_REJECT;
          end else begin
            resp_status_d = psrq_pkg::ST_ACCEPT;
            len_we        = 1'b1;
            count_d       = count_q + CountW'(1);
          end
          resp_valid_d = 1'b1;
          resp_len_d   = gather_q;
          gather_d     = '0;
          reject_d     = 1'b0;
        end
        psrq_pkg::CMD_POP: begin
          if (count_q == '0) begin
            resp_valid_d  = 1'b1;
            resp_status_d = psrq_pkg::ST_EMPTY;
            resp_len_d    = '0;
          end else begin
            head_d  = head_next;
            count_d = count_q - CountW'(1);
            if (head_len == '0) begin
              resp_valid_d  = 1'b1;
              resp_status_d = psrq_pkg::ST_BYTE;
              resp_len_d    = '0;
            end else begin
              stream_d = 1'b1;
              idx_d    = '0;
              slen_d   = head_len;
              sslot_d  = head_q;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      count_q      <= '0;
      gather_q     <= '0;
      reject_q     <= 1'b0;
      resp_valid_q <= 1'b0;
      stream_q     <= 1'b0;
    end else begin
      head_q       <= head_d;
      count_q      <= count_d;
      gather_q     <= gather_d;
      reject_q     <= reject_d;
      resp_valid_q <= resp_valid_d;
      stream_q     <= stream_d;
    end
  end

  always_ff @(posedge clk_i) begin
    resp_status_q <= resp_status_d;
    resp_len_q    <= resp_len_d;
    idx_q         <= idx_d;
    slen_q        <= slen_d;
    sslot_q       <= sslot_d;
    if (len_we) begin
      len_q[tail] <= gather_q;
    end
  end

  // streamed bytes come straight from the memory read register
  assign strobe          = resp_valid_q || stream_q;
  assign status_o        = stream_q ? psrq_pkg::StatusW'(psrq_pkg::ST_BYTE)
                                    : psrq_pkg::StatusW'(resp_status_q);
  assign out_byte_o      = stream_q ? ram_rdata : '0;
  assign byte_valid_o    = stream_q;
  assign packet_length_o = stream_q ? slen_q : resp_len_q;
  assign last_o          = stream_q ? last_beat : 1'b1;
  assign queue_count_o   = count_q;

endmodule
